// ===== design/rlv_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlv_pkg
// Shared types, codes and constants of the radial light vignette pipeline.
// ---------------------------------------------------------------------------
package rlv_pkg;

   // light modes
   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_AMBIENT = 2'd1,
      MODE_PLAYER  = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   // brightness source picked after the distance compare
   typedef enum logic [1:0] {
      SEL_RAMP  = 2'd0,
      SEL_FULL  = 2'd1,
      SEL_FLOOR = 2'd2
   } sel_type;

   // register indexes of the csr port
   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_WIDTH  = 3'd1;
   localparam logic [2:0] REG_TOP    = 3'd2;
   localparam logic [2:0] REG_BOTTOM = 3'd3;
   localparam logic [2:0] REG_LX     = 3'd4;
   localparam logic [2:0] REG_LY     = 3'd5;

   localparam int SQRT_STEPS = 18;
   localparam int DIV_STEPS  = 16;

   // player radii in q12.4
   localparam logic [15:0] PLY_CORE_Q = 16'd1344;
   localparam logic [15:0] PLY_EDGE_Q = 16'd3520;

   // one minus floor, q0.16
   localparam logic [15:0] AMB_FDIFF = 16'd36045;
   localparam logic [15:0] PLY_FDIFF = 16'd45875;

   // floor brightness rounded to q8
   localparam logic [8:0] AMB_FLOOR_Q8 = 9'd115;
   localparam logic [8:0] PLY_FLOOR_Q8 = 9'd77;
   localparam logic [8:0] FULL_Q8      = 9'd256;

   typedef struct packed {
      mode_type           mode;
      logic [11:0]        width;
      logic [11:0]        top;
      logic [11:0]        bottom;
      logic signed [12:0] light_x;
      logic signed [12:0] light_y;
   } cfg_type;

   // item context carried alongside the distance
   typedef struct packed {
      logic [31:0] pixel;
      logic        bypass;
      logic        amb;
      logic [15:0] core;
      logic [15:0] edge_q;
   } side_type;

   // item context carried alongside the ramp value
   typedef struct packed {
      logic [31:0] pixel;
      logic        bypass;
      logic        amb;
      sel_type     sel;
   } shade_type;

   // round(r * 3.2) for the remainder of width / 5
   function automatic logic [3:0] core_tab(input logic [2:0] r);
      logic [3:0] v;
      case (r)
         3'd0:    v = 4'd0;
         3'd1:    v = 4'd3;
         3'd2:    v = 4'd6;
         3'd3:    v = 4'd10;
         3'd4:    v = 4'd13;
         default: v = 4'd0;
      endcase
      return v;
   endfunction

   // floor(r * 9.92 + 0.5) for the remainder of width / 25
   function automatic logic [7:0] edge_tab(input logic [4:0] r);
      logic [7:0] v;
      case (r)
         5'd0:  v = 8'd0;
         5'd1:  v = 8'd10;
         5'd2:  v = 8'd20;
         5'd3:  v = 8'd30;
         5'd4:  v = 8'd40;
         5'd5:  v = 8'd50;
         5'd6:  v = 8'd60;
         5'd7:  v = 8'd69;
         5'd8:  v = 8'd79;
         5'd9:  v = 8'd89;
         5'd10: v = 8'd99;
         5'd11: v = 8'd109;
         5'd12: v = 8'd119;
         5'd13: v = 8'd129;
         5'd14: v = 8'd139;
         5'd15: v = 8'd149;
         5'd16: v = 8'd159;
         5'd17: v = 8'd169;
         5'd18: v = 8'd179;
         5'd19: v = 8'd188;
         5'd20: v = 8'd198;
         5'd21: v = 8'd208;
         5'd22: v = 8'd218;
         5'd23: v = 8'd228;
         5'd24: v = 8'd238;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== design/radial_light_vignette.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// radial_light_vignette
// Scales the rgb of an argb pixel stream by a radial smoothstep brightness.
//
//  channel | direction | ports                     | payload
//  req     | in        | req_tvalid/tready/tdata   | pixel_in, column, row
//  rsp     | out       | rsp_tvalid/tready/tdata   | pixel_out
//  csr     | in        | csr_valid/ready/index/data| register writes, always ready
//
// One pixel per clock while the skid register is empty; the pipeline
// holds the 18-stage square root and the 16-stage divider.
// Synchronous active-high reset clears all valid bits and resets the csr registers.
// A stall on rsp parks one item in a skid register and freezes the
// pipeline; req_tready falls only while the skid register is full.
// ---------------------------------------------------------------------------
module radial_light_vignette (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // pixel_in[31:0], column[43:32], row[55:44]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pixel_out[31:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_data
);
   import rlv_pkg::*;

   cfg_type   cfg;
   logic [1:0]         mode_ff;
   logic [11:0]        width_ff, top_ff, bottom_ff;
   logic signed [12:0] lx_ff, ly_ff;

   logic      en;
   logic      g_valid, s_valid, r_valid, p_valid;
   logic [34:0] g_rad;
   side_type  g_side, s_side;
   logic [17:0] s_root;
   logic [15:0] r_t;
   shade_type r_shade;
   logic [31:0] p_pixel;

   logic        rsp_v_ff, skid_v_ff;
   logic [31:0] rsp_d_ff, skid_d_ff;
   logic        out_free;

   // configuration registers
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_OFF;
         width_ff  <= '0;
         top_ff    <= '0;
         bottom_ff <= '0;
         lx_ff     <= -13'sd1;
         ly_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MODE:   mode_ff   <= csr_data[1:0];
            REG_WIDTH:  width_ff  <= csr_data[11:0];
            REG_TOP:    top_ff    <= csr_data[11:0];
            REG_BOTTOM: bottom_ff <= csr_data[11:0];
            REG_LX:     lx_ff     <= $signed(csr_data);
            REG_LY:     ly_ff     <= $signed(csr_data);
            default:    ;
         endcase
      end
   end

   always_comb begin
      cfg.mode    = mode_type'(mode_ff);
      cfg.width   = width_ff;
      cfg.top     = top_ff;
      cfg.bottom  = bottom_ff;
      cfg.light_x = lx_ff;
      cfg.light_y = ly_ff;
   end

   // pipeline advances while the skid register is empty
   assign en         = !skid_v_ff;
   assign req_tready = en;

   rlv_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_pixel  (req_tdata[31:0]),
      .in_column (req_tdata[43:32]),
      .in_row    (req_tdata[55:44]),
      .out_valid (g_valid),
      .out_rad   (g_rad),
      .out_side  (g_side)
   );

   rlv_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_valid),
      .in_rad    (g_rad),
      .in_side   (g_side),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   rlv_ramp u_ramp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_dist   (s_root),
      .in_side   (s_side),
      .out_valid (r_valid),
      .out_t     (r_t),
      .out_shade (r_shade)
   );

   rlv_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r_valid),
      .in_t      (r_t),
      .in_shade  (r_shade),
      .out_valid (p_valid),
      .out_pixel (p_pixel)
   );

   // output register with skid
   assign out_free = !rsp_v_ff || rsp_tready;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (out_free) begin
            rsp_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end
      end else if (out_free) begin
         rsp_v_ff <= p_valid;
      end else if (p_valid) begin
         skid_v_ff <= 1'b1;
      end
      if (skid_v_ff) begin
         if (out_free) begin
            rsp_d_ff <= skid_d_ff;
         end
      end else if (out_free) begin
         rsp_d_ff <= p_pixel;
      end else begin
         skid_d_ff <= p_pixel;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

endmodule

// ===== design/rlv_geom.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlv_geom
// Three stages: centre and offsets, radii and squares, squared distance.
// ---------------------------------------------------------------------------
module rlv_geom (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  rlv_pkg::cfg_type cfg,
   input  logic             in_valid,
   input  logic [31:0]      in_pixel,
   input  logic [11:0]      in_column,
   input  logic [11:0]      in_row,
   output logic             out_valid,
   output logic [34:0]      out_rad,
   output rlv_pkg::side_type out_side
);
   import rlv_pkg::*;

   logic              amb, active, use_view, bypass;
   logic signed [19:0] cx, cy, dx, dy;
   logic [19:0]       adx_w, ady_w;
   logic [25:0]       prod5;
   logic [23:0]       prod25;
   logic [12:0]       rsum;

   // stage 1 registers
   logic        v1_ff;
   logic [31:0] pix1_ff;
   logic        byp1_ff, amb1_ff;
   logic [16:0] adx1_ff, ady1_ff;
   logic [9:0]  q5_1_ff;
   logic [7:0]  q25_1_ff;
   logic [11:0] w1_ff;

   // stage 2 registers
   logic        v2_ff;
   logic [33:0] sqx2_ff, sqy2_ff;
   side_type    side2_ff;
   logic [11:0] r5_full, r25_full;
   logic [15:0] core_amb, edge_amb;

   // stage 3 registers
   logic        v3_ff;
   logic [34:0] rad3_ff;
   side_type    side3_ff;

   // mode decode and passthrough test
   always_comb begin
      amb      = (cfg.mode == MODE_AMBIENT);
      active   = amb || (cfg.mode == MODE_PLAYER);
      use_view = amb || cfg.light_x[12];
      bypass   = !active || (cfg.width == 12'd0) || (cfg.bottom <= cfg.top) ||
                 (in_row < cfg.top) || (in_row >= cfg.bottom) ||
                 (in_column >= cfg.width);
      rsum     = {1'b0, cfg.top} + {1'b0, cfg.bottom};
      if (use_view) begin
         cx = $signed({5'd0, cfg.width, 3'd0});
         cy = $signed({4'd0, rsum, 3'd0});
      end else begin
         cx = $signed({{3{cfg.light_x[12]}}, cfg.light_x, 4'd0});
         cy = $signed({{3{cfg.light_y[12]}}, cfg.light_y, 4'd0});
      end
      dx     = $signed({4'd0, in_column, 4'd0}) - cx;
      dy     = $signed({4'd0, in_row, 4'd0}) - cy;
      adx_w  = dx[19] ? 20'(-dx) : 20'(dx);
      ady_w  = dy[19] ? 20'(-dy) : 20'(dy);
      prod5  = {14'd0, cfg.width} * 26'd13108;
      prod25 = {12'd0, cfg.width} * 24'd2622;
   end

   // stage 1: offsets and width quotients
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         pix1_ff  <= in_pixel;
         byp1_ff  <= bypass;
         amb1_ff  <= amb;
         adx1_ff  <= adx_w[16:0];
         ady1_ff  <= ady_w[16:0];
         q5_1_ff  <= prod5[25:16];
         q25_1_ff <= prod25[23:16];
         w1_ff    <= cfg.width;
      end
   end

   // radii from quotient and remainder
   always_comb begin
      r5_full  = w1_ff - ({2'd0, q5_1_ff} * 12'd5);
      r25_full = w1_ff - ({4'd0, q25_1_ff} * 12'd25);
      core_amb = {2'd0, q5_1_ff, 4'd0} + {12'd0, core_tab(r5_full[2:0])};
      edge_amb = ({8'd0, q25_1_ff} * 16'd248) + {8'd0, edge_tab(r25_full[4:0])};
   end

   // stage 2: radii and squares
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         sqx2_ff         <= {17'd0, adx1_ff} * {17'd0, adx1_ff};
         sqy2_ff         <= {17'd0, ady1_ff} * {17'd0, ady1_ff};
         side2_ff.pixel  <= pix1_ff;
         side2_ff.bypass <= byp1_ff;
         side2_ff.amb    <= amb1_ff;
         side2_ff.core   <= amb1_ff ? core_amb : PLY_CORE_Q;
         side2_ff.edge_q <= amb1_ff ? edge_amb : PLY_EDGE_Q;
      end
   end

   // stage 3: squared distance
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         rad3_ff  <= {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
         side3_ff <= side2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_rad   = rad3_ff;
   assign out_side  = side3_ff;

endmodule

// ===== design/rlv_isqrt.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlv_isqrt
// Pipelined floor square root, one root bit per stage.
// ---------------------------------------------------------------------------
module rlv_isqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [34:0]       in_rad,
   input  rlv_pkg::side_type in_side,
   output logic              out_valid,
   output logic [17:0]       out_root,
   output rlv_pkg::side_type out_side
);
   import rlv_pkg::*;

   typedef struct packed {
      logic [35:0] rad;
      logic [19:0] rem;
      logic [17:0] root;
      side_type    side;
   } sq_type;

   // one digit step of the restoring square root
   function automatic sq_type sq_step(input sq_type a);
      logic [21:0] r2;
      logic [21:0] tr;
      sq_type      b;
      b     = a;
      r2    = {a.rem, a.rad[35:34]};
      tr    = {2'd0, a.root, 2'b01};
      b.rad = {a.rad[33:0], 2'b00};
      if (r2 >= tr) begin
         b.rem  = 20'(r2 - tr);
         b.root = {a.root[16:0], 1'b1};
      end else begin
         b.rem  = r2[19:0];
         b.root = {a.root[16:0], 1'b0};
      end
      return b;
   endfunction

   sq_type st_ff [SQRT_STEPS];
   logic   v_ff  [SQRT_STEPS];
   sq_type src   [SQRT_STEPS];
   logic   vsrc  [SQRT_STEPS];

   // stage chain
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      if (k == 0) begin : g_first
         assign src[k]  = '{rad: {1'b0, in_rad}, rem: '0, root: '0, side: in_side};
         assign vsrc[k] = in_valid;
      end else begin : g_next
         assign src[k]  = st_ff[k-1];
         assign vsrc[k] = v_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= vsrc[k];
         end
         if (en) begin
            st_ff[k] <= sq_step(src[k]);
         end
      end
   end

   assign out_valid = v_ff[SQRT_STEPS-1];
   assign out_root  = st_ff[SQRT_STEPS-1].root;
   assign out_side  = st_ff[SQRT_STEPS-1].side;

endmodule

// ===== design/rlv_ramp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlv_ramp
// Distance compare against the radii, then a pipelined divider that
// forms t = (d - core) / span in q0.16, one quotient bit per stage.
// ---------------------------------------------------------------------------
module rlv_ramp (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [17:0]        in_dist,
   input  rlv_pkg::side_type  in_side,
   output logic               out_valid,
   output logic [15:0]        out_t,
   output rlv_pkg::shade_type out_shade
);
   import rlv_pkg::*;

   typedef struct packed {
      logic [15:0] rem;
      logic [15:0] span;
      logic [15:0] quo;
      shade_type   shade;
   } dv_type;

   // one bit of restoring division
   function automatic dv_type dv_step(input dv_type a);
      logic [16:0] r2;
      dv_type      b;
      b  = a;
      r2 = {a.rem, 1'b0};
      if (r2 >= {1'b0, a.span}) begin
         b.rem = 16'(r2 - {1'b0, a.span});
         b.quo = {a.quo[14:0], 1'b1};
      end else begin
         b.rem = r2[15:0];
         b.quo = {a.quo[14:0], 1'b0};
      end
      return b;
   endfunction

   logic   vc_ff;
   dv_type cmp_ff;
   dv_type cmp_in;
   dv_type st_ff [DIV_STEPS];
   logic   v_ff  [DIV_STEPS];
   dv_type src   [DIV_STEPS];
   logic   vsrc  [DIV_STEPS];

   // compare stage
   always_comb begin
      cmp_in.rem          = 16'(in_dist - {2'd0, in_side.core});
      cmp_in.span         = in_side.edge_q - in_side.core;
      cmp_in.quo          = '0;
      cmp_in.shade.pixel  = in_side.pixel;
      cmp_in.shade.bypass = in_side.bypass;
      cmp_in.shade.amb    = in_side.amb;
      if (in_dist <= {2'd0, in_side.core}) begin
         cmp_in.shade.sel = SEL_FULL;
      end else if (in_dist >= {2'd0, in_side.edge_q}) begin
         cmp_in.shade.sel = SEL_FLOOR;
      end else begin
         cmp_in.shade.sel = SEL_RAMP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (en) begin
         vc_ff <= in_valid;
      end
      if (en) begin
         cmp_ff <= cmp_in;
      end
   end

   // divider chain
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      if (k == 0) begin : g_first
         assign src[k]  = cmp_ff;
         assign vsrc[k] = vc_ff;
      end else begin : g_next
         assign src[k]  = st_ff[k-1];
         assign vsrc[k] = v_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= vsrc[k];
         end
         if (en) begin
            st_ff[k] <= dv_step(src[k]);
         end
      end
   end

   assign out_valid = v_ff[DIV_STEPS-1];
   assign out_t     = st_ff[DIV_STEPS-1].quo;
   assign out_shade = st_ff[DIV_STEPS-1].shade;

endmodule

// ===== design/rlv_shade.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rlv_shade
// Smoothstep, floor blend, q8 rounding and channel scaling in five stages.
// ---------------------------------------------------------------------------
module rlv_shade (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [15:0]        in_t,
   input  rlv_pkg::shade_type in_shade,
   output logic               out_valid,
   output logic [31:0]        out_pixel
);
   import rlv_pkg::*;

   logic        va_ff, vb_ff, vc_ff, vd_ff, ve_ff;
   shade_type   sa_ff, sb_ff, sc_ff, sd_ff;
   logic [31:0] prod_a;
   logic [15:0] t2a_ff;
   logic [17:0] ka_ff;
   logic [33:0] prod_b;
   logic [17:0] sb_val_ff;
   logic [33:0] prod_c;
   logic [16:0] bright_c_ff;
   logic [17:0] bsum;
   logic [9:0]  q8_raw;
   logic [8:0]  q8_in, q8_d_ff;
   logic [16:0] pr, pg, pb;
   logic [31:0] pixel_e_ff;

   // stage a: t squared and the cubic factor
   assign prod_a = in_t * in_t;
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
      end
      if (en) begin
         t2a_ff <= prod_a[31:16];
         ka_ff  <= 18'd196608 - {1'b0, in_t, 1'b0};
         sa_ff  <= in_shade;
      end
   end

   // stage b: smoothstep value
   assign prod_b = {18'd0, t2a_ff} * {16'd0, ka_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
      if (en) begin
         sb_val_ff <= prod_b[33:16];
         sb_ff     <= sa_ff;
      end
   end

   // stage c: blend toward the floor
   assign prod_c = {16'd0, sb_val_ff} * {18'd0, (sb_ff.amb ? AMB_FDIFF : PLY_FDIFF)};
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (en) begin
         vc_ff <= vb_ff;
      end
      if (en) begin
         bright_c_ff <= 17'(18'd65536 - prod_c[33:16]);
         sc_ff       <= sb_ff;
      end
   end

   // stage d: round to q8 and pick the source
   always_comb begin
      bsum   = {1'b0, bright_c_ff} + 18'd128;
      q8_raw = bsum[17:8];
      case (sc_ff.sel)
         SEL_FULL:  q8_in = FULL_Q8;
         SEL_FLOOR: q8_in = sc_ff.amb ? AMB_FLOOR_Q8 : PLY_FLOOR_Q8;
         default:   q8_in = (q8_raw > 10'd256) ? FULL_Q8 : q8_raw[8:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (en) begin
         vd_ff <= vc_ff;
      end
      if (en) begin
         q8_d_ff <= q8_in;
         sd_ff   <= sc_ff;
      end
   end

   // stage e: scale rgb, keep alpha; bypass items pass through unchanged
   always_comb begin
      pr = {9'd0, sd_ff.pixel[23:16]} * {8'd0, q8_d_ff};
      pg = {9'd0, sd_ff.pixel[15:8]}  * {8'd0, q8_d_ff};
      pb = {9'd0, sd_ff.pixel[7:0]}   * {8'd0, q8_d_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (en) begin
         ve_ff <= vd_ff;
      end
      if (en) begin
         pixel_e_ff <= sd_ff.bypass ? sd_ff.pixel :
                       {sd_ff.pixel[31:24], pr[15:8], pg[15:8], pb[15:8]};
      end
   end

   assign out_valid = ve_ff;
   assign out_pixel = pixel_e_ff;

endmodule

// ===== verif/radial_light_vignette_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// radial_light_vignette_tb
// Drives argb pixels with column and row through the vignette pipeline under
// several register settings, predicts each shaded pixel in fixed point and
// compares it in order, with random idling on both streams and a long
// receiver hold-off that fills the pipeline.
// ---------------------------------------------------------------------------
module radial_light_vignette_tb;
   import rlv_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;    // pixel_in[31:0], column[43:32], row[55:44]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // pixel_out[31:0]
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [12:0] csr_data = '0;

   radial_light_vignette dut (.*);

   always #6 clock = ~clock;

   // shadow of the light registers
   mode_type           sh_mode;
   logic [11:0]        sh_width, sh_top, sh_bottom;
   logic signed [12:0] sh_lx, sh_ly;

   logic [31:0] shaded_q[$];
   int          errors = 0;
   bit          quiet = 0;      // no idling near the end
   bit          hold_rsp = 0;   // long receiver hold-off request

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // expected shaded pixel for one item under the current registers
   function automatic logic [31:0] shade_pixel(input logic [31:0] px,
                                               input logic [11:0] col,
                                               input logic [11:0] row);
      longint cx, cy, core, edg, dx, dy, d, span;
      longint unsigned t, t2, s, bright, fl, q8;
      logic [31:0] o;
      if (!(sh_mode inside {MODE_AMBIENT, MODE_PLAYER}) || sh_width == 0 ||
          sh_bottom <= sh_top || row < sh_top || row >= sh_bottom ||
          col >= sh_width)
         return px;
      cx = (longint'(sh_width) * 16) / 2;
      cy = ((longint'(sh_top) + longint'(sh_bottom)) * 16) / 2;
      if (sh_mode == MODE_AMBIENT) begin
         core = (longint'(sh_width) * 32 + 5) / 10;
         edg = (longint'(sh_width) * 16 * 62 + 50) / 100;
         fl = 29491;
      end else begin
         if (sh_lx >= 0) begin
            cx = longint'(sh_lx) * 16;
            cy = longint'(sh_ly) * 16;
         end
         core = 84 * 16;
         edg = 220 * 16;
         fl = 19661;
      end
      dx = longint'(col) * 16 - cx;
      dy = longint'(row) * 16 - cy;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      d = longint'(root_floor(dx * dx + dy * dy));
      if (d <= core) bright = 65536;
      else if (d >= edg) bright = fl;
      else begin
         span = (edg > core) ? edg - core : 16;
         t = ((d - core) << 16) / span;
         if (t > 65536) t = 65536;
         t2 = (t * t) >> 16;
         s = (t2 * (3 * 65536 - 2 * t)) >> 16;
         bright = 65536 - ((s * (65536 - fl)) >> 16);
      end
      q8 = (bright + 128) >> 8;
      if (q8 > 256) q8 = 256;
      o[31:24] = px[31:24];
      o[23:16] = 8'((px[23:16] * q8) >> 8);
      o[15:8]  = 8'((px[15:8] * q8) >> 8);
      o[7:0]   = 8'((px[7:0] * q8) >> 8);
      return o;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_MODE:   sh_mode = mode_type'(val[1:0]);
         REG_WIDTH:  sh_width = val[11:0];
         REG_TOP:    sh_top = val[11:0];
         REG_BOTTOM: sh_bottom = val[11:0];
         REG_LX:     sh_lx = val;
         REG_LY:     sh_ly = val;
         default: ;
      endcase
   endtask

   task automatic set_light(input mode_type m, input logic [11:0] w,
                            input logic [11:0] tp, input logic [11:0] bt,
                            input logic [12:0] lx, input logic [12:0] ly);
      write_reg(REG_MODE, 13'(m));
      write_reg(REG_WIDTH, 13'(w));
      write_reg(REG_TOP, 13'(tp));
      write_reg(REG_BOTTOM, 13'(bt));
      write_reg(REG_LX, lx);
      write_reg(REG_LY, ly);
      csr_valid <= 1'b0;
   endtask

   // one item, with optional typed-in expectation
   task automatic send_pixel(input logic [31:0] px, input logic [11:0] col,
                             input logic [11:0] row, input bit typed,
                             input logic [31:0] typed_px);
      logic [31:0] e;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {row, col, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      e = shade_pixel(px, col, row);
      if (typed && typed_px !== e) begin
         $display("%0t typed row mismatch: expected %h actual %h", $time, typed_px, e);
         errors++;
      end
      shaded_q.push_back(e);
   endtask

   task automatic drain;
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      while (shaded_q.size() != 0 && n < 200000) begin
         @(posedge clock);
         n++;
      end
      repeat (60) @(posedge clock);
   endtask

   // receiver: random stalls and one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (150) @(posedge clock);
            hold_rsp = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 4)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (shaded_q.size() == 0) begin
            $display("%0t unexpected pixel: expected none actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            if (rsp_tdata !== shaded_q[0]) begin
               $display("%0t pixel mismatch: expected %h actual %h",
                        $time, shaded_q[0], rsp_tdata);
               errors++;
            end
            void'(shaded_q.pop_front());
         end
      end
   end

   initial begin
      #40ms;
      $display("radial_light_vignette_tb failed");
      $finish;
   end

   typedef struct {
      logic [31:0] px;
      logic [11:0] col, row;
      bit          typed;
      logic [31:0] want;
   } pix_row_type;

   pix_row_type dir_tab[12];

   initial begin
      int k, n;
      logic [11:0] w, tp, bt;
      sh_mode = MODE_OFF; sh_width = 0; sh_top = 0; sh_bottom = 0;
      sh_lx = -1; sh_ly = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset every pixel passes through
      dir_tab[0] = '{32'hFFFFFFFF, 12'd0, 12'd0, 1, 32'hFFFFFFFF};
      dir_tab[1] = '{32'h00000000, 12'hFFF, 12'hFFF, 1, 32'h00000000};
      foreach (dir_tab[i]) if (i < 2) send_pixel(dir_tab[i].px, dir_tab[i].col,
                                                  dir_tab[i].row, dir_tab[i].typed,
                                                  dir_tab[i].want);
      drain();

      // ambient, 320 wide playfield rows 8..247: centre full, corner floor
      set_light(MODE_AMBIENT, 320, 8, 248, -13'sd1, 0);
      dir_tab[2]  = '{32'h12FFFFFF, 12'd160, 12'd128, 1, 32'h12FFFFFF};
      dir_tab[3]  = '{32'hABFFFFFF, 12'd319, 12'd8, 0, 0};
      dir_tab[4]  = '{32'h55808080, 12'd320, 12'd100, 1, 32'h55808080};
      dir_tab[5]  = '{32'h55808080, 12'd10, 12'd7, 1, 32'h55808080};
      dir_tab[6]  = '{32'h55808080, 12'd10, 12'd248, 1, 32'h55808080};
      dir_tab[7]  = '{32'hFF00FF00, 12'd60, 12'd40, 0, 0};
      for (k = 2; k < 8; k++)
         send_pixel(dir_tab[k].px, dir_tab[k].col, dir_tab[k].row,
                    dir_tab[k].typed, dir_tab[k].want);
      drain();

      // player torch at a far light, negative light_y
      set_light(MODE_PLAYER, 4095, 0, 4095, 13'sd4095, -13'sd4096);
      dir_tab[8]  = '{32'hFFFFFFFF, 12'd0, 12'd0, 1, 32'hFF4C4C4C};
      dir_tab[9]  = '{32'hFFFFFFFF, 12'd4094, 12'd4094, 1, 32'hFF4C4C4C};
      for (k = 8; k < 10; k++)
         send_pixel(dir_tab[k].px, dir_tab[k].col, dir_tab[k].row,
                    dir_tab[k].typed, dir_tab[k].want);
      drain();

      // unused mode and empty playfield both pass through
      set_light(MODE_UNUSED, 100, 0, 100, 0, 0);
      send_pixel(32'h89ABCDEF, 12'd5, 12'd5, 1, 32'h89ABCDEF);
      drain();
      set_light(MODE_AMBIENT, 100, 50, 50, 0, 0);
      send_pixel(32'h89ABCDEF, 12'd5, 12'd50, 1, 32'h89ABCDEF);
      drain();

      // random phases, pixels mostly inside the playfield
      for (int ph = 0; ph < 14; ph++) begin
         w = (ph == 0) ? 12'd4095 : (ph == 1) ? 12'd1 : 12'($urandom_range(1, 700));
         tp = 12'($urandom_range(0, 60));
         bt = (ph == 2) ? 12'd4095 : 12'(tp + $urandom_range(1, 500));
         set_light((ph % 3 == 2) ? mode_type'($urandom_range(0, 3))
                                 : ((ph % 2) ? MODE_PLAYER : MODE_AMBIENT),
                   w, tp, bt,
                   (ph % 4 == 0) ? -13'sd1 : 13'($urandom_range(0, 8191)),
                   13'($urandom_range(0, 8191)));
         if (ph == 13) quiet = 1;
         n = (ph == 5) ? 250 : 120;
         for (k = 0; k < n; k++) begin
            if (ph == 5 && k == 20) hold_rsp = 1;
            if ($urandom_range(0, 9) == 0)
               send_pixel($urandom, 12'($urandom), 12'($urandom), 0, 0);
            else
               send_pixel($urandom, 12'($urandom_range(0, w)),
                          12'($urandom_range(tp, (bt > tp) ? bt - 1 : tp)), 0, 0);
         end
         drain();
      end

      if (errors == 0 && shaded_q.size() == 0)
         $display("radial_light_vignette_tb passed");
      else
         $display("radial_light_vignette_tb failed");
      $finish;
   end
endmodule
